// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/gwsc_pkg.sv =====
package gwsc_pkg;

	localparam int MAX_ROWS  = 64;
	localparam int MAX_COLS  = 64;
	localparam int MAX_STEPS = 31;
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int CELL_W    = 63;
	localparam int CFG_W     = 7;
	localparam int STEP_W    = 5;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	typedef struct packed {
		logic [5:0] start_row;
		logic [5:0] start_col;
		logic [4:0] steps;
	} query_t;

	typedef struct packed {
		logic [62:0] survive_count;
		logic [32:0] probability_q32;
	} result_t;

	// Controller commands for the datapath.
	typedef struct packed {
		logic             load;     // latch query and grid size
		logic             clr_pos;  // restart the cell scan
		logic             adv_pos;  // move to the next cell
		logic             rd_src;   // issue neighbor reads for the current cell
		logic [1:0]       rd_slot;  // which neighbor read is issued
		logic             wr_cell;  // write the accumulated sum
		logic             init;     // writes are ones (layer zero)
		logic             layer_odd;// destination parity
		logic             rd_res;   // read the result cell
		logic             cap_res;  // capture the result
		logic             zero_res; // start outside the grid
	} dp_cmd_t;

	typedef struct packed {
		logic last_cell;
		logic in_grid;
		logic [STEP_W-1:0] steps;
	} dp_stat_t;

endpackage

// ===== src/grid_walk_survival_count.sv =====
// Channel  | Handshake                   | Beat
// query    | query_valid / query_ready   | start_row, start_col, steps
// result   | result_valid / result_ready | survive_count, probability_q32
// config   | cfg_we, cfg_index           | cfg_wdata (7 bits)
//
// Every cell of a layer takes four reads through the single read port of
// the layer memory, a drain of the registered read into the sum and one
// write. A start outside the grid skips the layers; its result is zero.
// Reset clears the controller and the result flag and sets the grid size to 64 by 64.
// A waiting result holds while the next query is taken and computed; the new
// count stalls before capture until the waiting beat leaves.
module grid_walk_survival_count (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 query_valid,
	output logic                 query_ready,
	input  gwsc_pkg::query_t     query,
	output logic                 result_valid,
	input  logic                 result_ready,
	output gwsc_pkg::result_t    result,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [6:0]           cfg_wdata
);
	import gwsc_pkg::*;

	logic [CFG_W-1:0] rows_q, cols_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	result_t  res;

	// Hold the grid size; the user must write it only while idle, not enforced here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd64;
			cols_q <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS: rows_q <= cfg_wdata;
				CFG_COLS: cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	gwsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (query_valid),
		.in_ready  (query_ready),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gwsc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (query),
		.grid_rows (rows_q),
		.grid_cols (cols_q),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

	assign result = res;

endmodule

// ===== src/gwsc_datapath.sv =====
`include "assert_macros.svh"

module gwsc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  gwsc_pkg::query_t    query,
	input  logic [6:0]          grid_rows,
	input  logic [6:0]          grid_cols,
	input  gwsc_pkg::dp_cmd_t   cmd,
	output gwsc_pkg::dp_stat_t  stat,
	output gwsc_pkg::result_t   res
);
	import gwsc_pkg::*;

	logic [CELL_W-1:0] mem_even [MAX_ROWS*MAX_COLS];
	logic [CELL_W-1:0] mem_odd  [MAX_ROWS*MAX_COLS];

	query_t            q_q;
	logic [ROW_W:0]    rows_q;
	logic [COL_W:0]    cols_q;
	logic [ROW_W-1:0]  r_q;
	logic [COL_W-1:0]  c_q;
	logic [CELL_W-1:0] acc_q;
	logic [CELL_W-1:0] rd_even_q, rd_odd_q;
	logic              rd_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
			cols_q <= '0;
			r_q    <= '0;
			c_q    <= '0;
		end else begin
			if (cmd.load) begin
				rows_q <= (grid_rows > 7'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS) : grid_rows[ROW_W:0];
				cols_q <= (grid_cols > 7'(MAX_COLS)) ? (COL_W+1)'(MAX_COLS) : grid_cols[COL_W:0];
			end
			if (cmd.clr_pos) begin
				r_q <= '0;
				c_q <= '0;
			end else if (cmd.adv_pos) begin
				if ({1'b0, c_q} + 1'b1 == cols_q) begin
					c_q <= '0;
					r_q <= r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) q_q <= query;
	end

	// Neighbor address for the read slot: up, down, left, right; the start cell on a result read.
	logic [ROW_W-1:0] nr;
	logic [COL_W-1:0] nc;
	logic             nok;
	always_comb begin
		nr  = r_q;
		nc  = c_q;
		nok = 1'b0;
		case (cmd.rd_slot)
			2'd0: begin nr = r_q - 1'b1; nok = (r_q != '0); end
			2'd1: begin nr = r_q + 1'b1; nok = ({1'b0, r_q} + 1'b1 < rows_q); end
			2'd2: begin nc = c_q - 1'b1; nok = (c_q != '0); end
			default: begin nc = c_q + 1'b1; nok = ({1'b0, c_q} + 1'b1 < cols_q); end
		endcase
		if (cmd.rd_res) begin
			nr  = q_q.start_row[ROW_W-1:0];
			nc  = q_q.start_col[COL_W-1:0];
			nok = 1'b1;
		end
	end

	logic [ADDR_W-1:0] rd_addr, wr_addr;
	assign rd_addr = {nr, nc};
	assign wr_addr = {r_q, c_q};

	logic [CELL_W-1:0] wr_data;
	assign wr_data = cmd.init ? CELL_W'(1) : acc_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_cell && !cmd.layer_odd) mem_even[wr_addr] <= wr_data;
		if (cmd.wr_cell &&  cmd.layer_odd) mem_odd[wr_addr]  <= wr_data;
		rd_even_q <= mem_even[rd_addr];
		rd_odd_q  <= mem_odd[rd_addr];
	end

	// Accumulate the previous read while the next is issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
			acc_q   <= '0;
		end else begin
			rd_ok_q <= cmd.rd_src && nok;
			if (cmd.rd_src && cmd.rd_slot == 2'd0) acc_q <= '0;
			else if (rd_ok_q) acc_q <= acc_q + (cmd.layer_odd ? rd_even_q : rd_odd_q);
			if (cmd.wr_cell) acc_q <= '0;
		end
	end

	logic [CELL_W-1:0] cnt;
	logic [5:0]        sh;
	assign cnt = q_q.steps[0] ? rd_odd_q : rd_even_q;
	assign sh  = {q_q.steps, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res <= '0;
		end else if (cmd.zero_res) begin
			res <= '0;
		end else if (cmd.cap_res) begin
			res.survive_count <= cnt;
			if (sh <= 6'd32) res.probability_q32 <= 33'({cnt, 32'b0} >> sh);
			else             res.probability_q32 <= 33'(cnt >> (sh - 6'd32));
		end
	end

	assign stat.last_cell = ({1'b0, r_q} + 1'b1 == rows_q) && ({1'b0, c_q} + 1'b1 == cols_q);
	assign stat.in_grid   = ({1'b0, q_q.start_row} < 7'(rows_q)) && ({1'b0, q_q.start_col} < 7'(cols_q));
	assign stat.steps     = q_q.steps;

	`ASSERT_IMPLY(a_pos_in_grid, clk, arst_n, cmd.wr_cell, ({1'b0, r_q} < rows_q) && ({1'b0, c_q} < cols_q), "write outside grid")
	`ASSERT_IMPLY(a_one_op, clk, arst_n, cmd.wr_cell, !cmd.rd_res, "write during result read")
	`ASSERT_NEXT(a_clr, clk, arst_n, cmd.clr_pos, r_q == '0 && c_q == '0, "scan not restarted")

endmodule

// ===== src/gwsc_ctrl.sv =====
`include "assert_macros.svh"

module gwsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  gwsc_pkg::dp_stat_t  stat,
	output gwsc_pkg::dp_cmd_t   cmd
);
	import gwsc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_CHECK = 8'b00000010,
		S_INIT  = 8'b00000100,
		S_RD    = 8'b00001000,
		S_WR    = 8'b00010000,
		S_RES   = 8'b00100000,
		S_CAP   = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t              st_q;
	logic [STEP_W-1:0]   layer_q;
	logic [2:0]          slot_q;

	logic out_ok;
	assign out_ok = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			layer_q   <= '0;
			slot_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if ((st_q == S_OUT) && out_ok) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE:  if (in_valid) st_q <= S_CHECK;
				S_CHECK: begin
					layer_q <= '0;
					st_q <= !stat.in_grid ? S_OUT : S_INIT;
				end
				S_INIT: if (stat.last_cell) begin
					if (stat.steps == '0) st_q <= S_RES;
					else begin
						layer_q <= 5'd1;
						slot_q  <= '0;
						st_q    <= S_RD;
					end
				end
				S_RD: begin
					slot_q <= slot_q + 1'b1;
					if (slot_q == 3'd5) st_q <= S_WR;
				end
				S_WR: begin
					slot_q <= '0;
					if (!stat.last_cell) st_q <= S_RD;
					else if (layer_q == stat.steps) st_q <= S_RES;
					else begin
						layer_q <= layer_q + 1'b1;
						st_q    <= S_RD;
					end
				end
				S_RES: if (out_ok) st_q <= S_CAP;
				S_CAP: st_q <= S_OUT;
				S_OUT: if (out_ok) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (st_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load      = (st_q == S_IDLE) && in_valid;
		cmd.clr_pos   = (st_q == S_CHECK) || ((st_q == S_INIT) && stat.last_cell)
			|| ((st_q == S_WR) && stat.last_cell);
		cmd.adv_pos   = (st_q == S_INIT) || (st_q == S_WR);
		cmd.init      = (st_q == S_INIT);
		cmd.wr_cell   = (st_q == S_INIT) || (st_q == S_WR);
		cmd.layer_odd = (st_q == S_INIT) ? 1'b0 : layer_q[0];
		cmd.rd_src    = (st_q == S_RD) && (slot_q < 3'd4);
		cmd.rd_slot   = slot_q[1:0];
		cmd.rd_res    = (st_q == S_RES);
		cmd.cap_res   = (st_q == S_CAP);
		cmd.zero_res  = (st_q == S_OUT) && out_ok && !stat.in_grid;
	end

	`ASSERT_IMPLY(a_ready_idle, clk, arst_n, in_ready, !cmd.wr_cell, "write while idle")
	`ASSERT_NEXT(a_out_set, clk, arst_n, (st_q == S_OUT) && out_ok, out_valid, "result not shown")
	`ASSERT_IMPLY(a_layer_rng, clk, arst_n, st_q == S_WR, layer_q != '0 && layer_q <= stat.steps, "layer out of range")

endmodule
